// ===== design/sdss_pkg.sv =====
// Shared types and constants for the signed segment-distance block.
// No dependencies; compile first.
package sdss_pkg;

    localparam int MAX_SEGMENTS_DEF = 16;
    localparam int COORD_WIDTH_DEF  = 32;

    localparam int DIST_W     = 32;
    localparam int MAG_W      = 31;
    localparam int ID_W       = 8;
    localparam int CNT_W      = 5;
    localparam int SEG_IDX_W  = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int QUOT_BITS  = 31;

    localparam logic [MAG_W-1:0]  MAG_MAX  = '1;
    localparam logic [DIST_W-1:0] DIST_MAX = {1'b0, MAG_MAX};

    // product schedule: len2, dot, cross, |c|^2, |e|^2 (two terms each)
    localparam int NUM_PROD = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SEGMENT_COUNT = 2'd0,
        REG_NEG_REGION_ID = 2'd1,
        REG_POS_REGION_ID = 2'd2
    } t_reg_idx;

    typedef enum logic {
        ACT_LOAD  = 1'b0,
        ACT_QUERY = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        RES_LOAD,
        RES_EMPTY,
        RES_DIST
    } t_res_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_LATCH,
        S_MUL,
        S_DECIDE,
        S_SQRT,
        S_DIV_INIT,
        S_DIV,
        S_ACC,
        S_DONE
    } t_state;

endpackage

// ===== design/sdss_ifs.sv =====
// Channel interfaces: input items, result items, configuration writes.
// Depends on sdss_pkg.
interface sdss_item_if #(
    parameter int COORD_WIDTH = sdss_pkg::COORD_WIDTH_DEF
);
    logic                                   valid;
    logic                                   ready;
    logic                                   action;
    logic        [sdss_pkg::SEG_IDX_W-1:0]  seg_index;
    logic signed [COORD_WIDTH-1:0]          start_x;
    logic signed [COORD_WIDTH-1:0]          start_y;
    logic signed [COORD_WIDTH-1:0]          end_x;
    logic signed [COORD_WIDTH-1:0]          end_y;
    logic signed [COORD_WIDTH-1:0]          point_x;
    logic signed [COORD_WIDTH-1:0]          point_y;

    modport source (output valid, action, seg_index, start_x, start_y, end_x, end_y,
                    point_x, point_y, input ready);
    modport sink   (input valid, action, seg_index, start_x, start_y, end_x, end_y,
                    point_x, point_y, output ready);
endinterface

interface sdss_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [sdss_pkg::DIST_W-1:0] signed_distance;
    logic        [sdss_pkg::ID_W-1:0]   region_id;
    logic                               no_segments;

    modport source (output valid, signed_distance, region_id, no_segments, input ready);
    modport sink   (input valid, signed_distance, region_id, no_segments, output ready);
endinterface

interface sdss_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [sdss_pkg::CFG_IDX_W-1:0]      index;
    logic [sdss_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/signed_distance_to_segment_set.sv =====
// Signed distance from a point to a table of 2D segments, one segment at a time.
// Depends on sdss_pkg and the interfaces in sdss_ifs.sv.
//
//  channel  | dir | transfer
//  ---------+-----+-------------------------------------------------------
//  i_item   | in  | load a segment (action 0) or query a point (action 1)
//  o_result | out | signed distance, region id, no-segments flag
//  i_cfg    | in  | register write: segment_count, negative/positive id
//
// A query works through the n active segments one after another, with the
// shared multiplier (10 products), the bit-serial square root (COORD_WIDTH+2
// steps) and, for a nearest point inside the segment, the restoring divider
// (31 steps) working in series; a load goes straight to its result.
// Reset clears control and config (positive id to 1); the segment table holds no reset.
// A finished result waits in the output register while the next item enters.
module signed_distance_to_segment_set #(
    parameter int MAX_SEGMENTS = sdss_pkg::MAX_SEGMENTS_DEF,
    parameter int COORD_WIDTH  = sdss_pkg::COORD_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sdss_item_if.sink       i_item,
    sdss_result_if.source   o_result,
    sdss_cfg_if.sink        i_cfg
);
    import sdss_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int DW  = CW + 1;           // coordinate difference
    localparam int PW  = 2 * CW + 2;       // one product
    localparam int AW  = 2 * CW + 3;       // sum of two products
    localparam int SQ  = CW + 2;           // root bits
    localparam int RW  = 2 * SQ;           // radicand bits
    localparam int DVW = (RW > SQ + QUOT_BITS) ? RW : SQ + QUOT_BITS;
    localparam int IW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int NW  = $clog2(MAX_SEGMENTS + 1);
    localparam int STW = $clog2((SQ > QUOT_BITS + 1) ? SQ : QUOT_BITS + 1);

    t_state     r_state, n_state;
    t_res_kind  r_kind;

    logic [CNT_W-1:0] r_seg_count;
    logic [ID_W-1:0]  r_neg_id, r_pos_id;

    // segment table
    logic [4*CW-1:0] mem [MAX_SEGMENTS];
    logic [4*CW-1:0] r_rdata;
    logic [IW-1:0]   w_wr_addr;
    logic            w_item_fire, w_load_we;

    logic [NW-1:0]   r_idx, r_n, w_n;
    logic signed [CW-1:0] r_px, r_py;
    logic signed [CW-1:0] w_ax, w_ay, w_bx, w_by;

    logic signed [DW-1:0] r_dx, r_dy, r_cx, r_cy, r_ex, r_ey;
    logic signed [DW-1:0] w_ma, w_mb;
    logic signed [PW-1:0] w_prod, r_prod;
    logic [STW-1:0]       r_step, r_ptag;
    logic                 r_pv;

    logic signed [AW-1:0] r_len2, r_dot, r_cross, r_dc, r_de;
    logic [AW-1:0]        w_abs_cross;
    logic                 r_perp;

    logic [RW-1:0]   r_rad;
    logic [SQ+1:0]   r_sq_rem, w_sq_new, w_sq_trial;
    logic [SQ-1:0]   r_root;

    logic [DVW-1:0]       r_rem, r_dsh, w_d31;
    logic [QUOT_BITS-1:0] r_q, w_q_next;
    logic                 w_div_sat, w_div_ge;

    logic [MAG_W-1:0] r_mag, r_best, w_root_sat;
    logic             r_best_neg, w_cross_pos;

    logic                     r_ovalid, r_onos;
    logic [DIST_W-1:0]        r_odist;
    logic [ID_W-1:0]          r_oid;
    logic                     w_out_free;

    assign w_item_fire = i_item.valid && i_item.ready;
    assign w_load_we   = w_item_fire && (i_item.action == ACT_LOAD)
                         && (int'(i_item.seg_index) < MAX_SEGMENTS);
    assign w_wr_addr   = IW'(i_item.seg_index);
    assign w_n = (int'(r_seg_count) > MAX_SEGMENTS) ? NW'(MAX_SEGMENTS) : NW'(r_seg_count);

    assign w_ax = r_rdata[CW-1:0];
    assign w_ay = r_rdata[2*CW-1:CW];
    assign w_bx = r_rdata[3*CW-1:2*CW];
    assign w_by = r_rdata[4*CW-1:3*CW];

    // table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_load_we) begin
            mem[w_wr_addr] <= {i_item.end_y, i_item.end_x, i_item.start_y, i_item.start_x};
        end
        r_rdata <= mem[r_idx[IW-1:0]];
    end

    // configuration registers
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_count <= '0;
            r_neg_id    <= '0;
            r_pos_id    <= ID_W'(1);
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (t_reg_idx'(i_cfg.index))
                REG_SEGMENT_COUNT: r_seg_count <= i_cfg.data[CNT_W-1:0];
                REG_NEG_REGION_ID: r_neg_id    <= i_cfg.data;
                REG_POS_REGION_ID: r_pos_id    <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // shared multiplier operand schedule
    always_comb begin
        case (r_step)
            STW'(0): begin w_ma = r_dx; w_mb = r_dx; end
            STW'(1): begin w_ma = r_dy; w_mb = r_dy; end
            STW'(2): begin w_ma = r_dx; w_mb = r_cx; end
            STW'(3): begin w_ma = r_dy; w_mb = r_cy; end
            STW'(4): begin w_ma = r_dx; w_mb = r_cy; end
            STW'(5): begin w_ma = r_dy; w_mb = r_cx; end
            STW'(6): begin w_ma = r_cx; w_mb = r_cx; end
            STW'(7): begin w_ma = r_cy; w_mb = r_cy; end
            STW'(8): begin w_ma = r_ex; w_mb = r_ex; end
            STW'(9): begin w_ma = r_ey; w_mb = r_ey; end
            default: begin w_ma = '0;   w_mb = '0;   end
        endcase
    end
    assign w_prod = w_ma * w_mb;

    // square root step: two radicand bits per cycle
    assign w_sq_new   = {r_sq_rem[SQ-1:0], r_rad[RW-1:RW-2]};
    assign w_sq_trial = {r_root, 2'b01};

    assign w_root_sat  = (DVW'(r_root) > DVW'(MAG_MAX)) ? MAG_MAX : MAG_W'(r_root);
    assign w_abs_cross = r_cross[AW-1] ? AW'(-r_cross) : AW'(r_cross);
    assign w_cross_pos = !r_cross[AW-1] && (r_cross != '0);

    // divider: the root is the divisor
    assign w_d31     = DVW'(r_root) << QUOT_BITS;
    assign w_div_sat = DVW'(w_abs_cross) >= w_d31;
    assign w_div_ge  = r_rem >= r_dsh;
    assign w_q_next  = {r_q[QUOT_BITS-2:0], w_div_ge};

    assign w_out_free = !r_ovalid || o_result.ready;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_item_fire) begin
                    n_state = (i_item.action == ACT_QUERY && w_n != '0) ? S_FETCH : S_DONE;
                end
            end
            S_FETCH:  n_state = S_LATCH;
            S_LATCH:  n_state = S_MUL;
            S_MUL: begin
                if (r_step == STW'(NUM_PROD)) n_state = S_DECIDE;
            end
            S_DECIDE: n_state = S_SQRT;
            S_SQRT: begin
                if (r_step == STW'(SQ - 1)) n_state = r_perp ? S_DIV_INIT : S_ACC;
            end
            S_DIV_INIT: n_state = w_div_sat ? S_ACC : S_DIV;
            S_DIV: begin
                if (r_step == STW'(QUOT_BITS - 1)) n_state = S_ACC;
            end
            S_ACC:    n_state = (r_idx + NW'(1) == r_n) ? S_DONE : S_FETCH;
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_item.ready = (r_state == S_IDLE);
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_px  <= i_item.point_x;
                r_py  <= i_item.point_y;
                r_n   <= w_n;
                r_idx <= '0;
                if (i_item.action == ACT_LOAD) r_kind <= RES_LOAD;
                else if (w_n == '0)            r_kind <= RES_EMPTY;
                else                           r_kind <= RES_DIST;
            end
            S_LATCH: begin
                r_dx   <= DW'(w_bx) - DW'(w_ax);
                r_dy   <= DW'(w_by) - DW'(w_ay);
                r_cx   <= DW'(r_px) - DW'(w_ax);
                r_cy   <= DW'(r_py) - DW'(w_ay);
                r_ex   <= DW'(r_px) - DW'(w_bx);
                r_ey   <= DW'(r_py) - DW'(w_by);
                r_step <= '0;
                r_pv   <= 1'b0;
            end
            S_MUL: begin
                r_prod <= w_prod;
                r_ptag <= r_step;
                r_pv   <= (r_step != STW'(NUM_PROD));
                r_step <= r_step + STW'(1);
                if (r_pv) begin
                    case (r_ptag)
                        STW'(0): r_len2  <= AW'(r_prod);
                        STW'(1): r_len2  <= r_len2 + AW'(r_prod);
                        STW'(2): r_dot   <= AW'(r_prod);
                        STW'(3): r_dot   <= r_dot + AW'(r_prod);
                        STW'(4): r_cross <= AW'(r_prod);
                        STW'(5): r_cross <= r_cross - AW'(r_prod);
                        STW'(6): r_dc    <= AW'(r_prod);
                        STW'(7): r_dc    <= r_dc + AW'(r_prod);
                        STW'(8): r_de    <= AW'(r_prod);
                        STW'(9): r_de    <= r_de + AW'(r_prod);
                        default: ;
                    endcase
                end
            end
            S_DECIDE: begin
                // before start or degenerate: start point; past end: end point
                if (r_dot[AW-1] || r_len2 == '0) begin
                    r_rad  <= RW'(r_dc);
                    r_perp <= 1'b0;
                end else if (r_dot > r_len2) begin
                    r_rad  <= RW'(r_de);
                    r_perp <= 1'b0;
                end else begin
                    r_rad  <= RW'(r_len2);
                    r_perp <= 1'b1;
                end
                r_sq_rem <= '0;
                r_root   <= '0;
                r_step   <= '0;
            end
            S_SQRT: begin
                r_rad  <= r_rad << 2;
                r_step <= r_step + STW'(1);
                if (w_sq_new >= w_sq_trial) begin
                    r_sq_rem <= w_sq_new - w_sq_trial;
                    r_root   <= {r_root[SQ-2:0], 1'b1};
                end else begin
                    r_sq_rem <= w_sq_new;
                    r_root   <= {r_root[SQ-2:0], 1'b0};
                end
                if (r_step == STW'(SQ - 1)) begin
                    // last root bit lands with the register update; saturate in DIV_INIT
                    r_mag <= '0;
                end
            end
            S_DIV_INIT: begin
                r_rem  <= DVW'(w_abs_cross);
                r_dsh  <= DVW'(r_root) << (QUOT_BITS - 1);
                r_q    <= '0;
                r_step <= '0;
                r_mag  <= MAG_MAX;
            end
            S_DIV: begin
                if (w_div_ge) r_rem <= r_rem - r_dsh;
                r_dsh  <= r_dsh >> 1;
                r_q    <= w_q_next;
                r_step <= r_step + STW'(1);
                r_mag  <= w_q_next;
            end
            S_ACC: begin : acc_blk
                logic [MAG_W-1:0] v_mag;
                v_mag = r_perp ? r_mag : w_root_sat;
                if (r_idx == '0 || v_mag < r_best) begin
                    r_best     <= v_mag;
                    r_best_neg <= w_cross_pos && (v_mag != '0);
                end
                r_idx <= r_idx + NW'(1);
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_ovalid <= 1'b1;
        end else if (o_result.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            case (r_kind)
                RES_LOAD: begin
                    r_odist <= '0;
                    r_oid   <= '0;
                    r_onos  <= 1'b0;
                end
                RES_EMPTY: begin
                    r_odist <= DIST_MAX;
                    r_oid   <= r_pos_id;
                    r_onos  <= 1'b1;
                end
                default: begin
                    r_odist <= r_best_neg ? -{1'b0, r_best} : {1'b0, r_best};
                    r_oid   <= (!r_best_neg && r_best != '0) ? r_pos_id : r_neg_id;
                    r_onos  <= 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        o_result.valid           = r_ovalid;
        o_result.signed_distance = r_odist;
        o_result.region_id       = r_oid;
        o_result.no_segments     = r_onos;
    end

    // checks
    a_fetch_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH) |-> (r_idx < r_n))
        else $error("segment fetch beyond active count");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_dsh != '0))
        else $error("divider shifted to zero");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.no_segments) |-> (o_result.signed_distance == DIST_MAX))
        else $error("empty query without saturated distance");

    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> (r_state != S_IDLE))
        else $error("accepted item did not start");

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for signed_distance_to_segment_set: loads, queries, register writes.
// Depends on sdss_pkg and the channel interfaces in design/sdss_ifs.sv.
module tb;
    import sdss_pkg::*;

    localparam int  PERIOD      = 10;
    localparam int  CYCLE_LIMIT = 4000000;
    localparam int  HOLD_CYCLES = 400;
    // index 3 is not a register; a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
    localparam logic [31:0] C_MIN = 32'h8000_0000;
    localparam logic [31:0] C_MAX = 32'h7FFF_FFFF;

    typedef struct {
        t_action          act;
        logic [3:0]       idx;
        logic [31:0]      sx, sy, ex, ey, px, py;
    } seg_item_t;

    typedef struct {
        logic [31:0] sdist;
        logic [7:0]  id;
        logic        nos;
    } dist_res_t;

    logic i_clk;
    logic i_rst_n;

    sdss_item_if   item_ch ();
    sdss_result_if res_ch ();
    sdss_cfg_if    cfg_ch ();

    signed_distance_to_segment_set i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (res_ch),
        .i_cfg    (cfg_ch)
    );

    // stimulus and expectation stores
    seg_item_t pending_items[$];
    dist_res_t expected_dist[$];

    // mirror of the block's table and registers
    logic signed [31:0] tab_sx[16], tab_sy[16], tab_ex[16], tab_ey[16];
    logic [4:0]  seg_count;
    logic [7:0]  neg_id, pos_id;

    logic item_fire, cfg_fire;
    bit   no_idle;
    bit   hold_go, hold_done;
    int   hold_left;
    int   mismatches;
    int   cycles;

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.action = ACT_LOAD;
        item_ch.seg_index = '0;
        item_ch.start_x = '0;
        item_ch.start_y = '0;
        item_ch.end_x = '0;
        item_ch.end_y = '0;
        item_ch.point_x = '0;
        item_ch.point_y = '0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        forever #(PERIOD/2) i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------

    function automatic logic [63:0] isqrt128(logic [127:0] v);
        logic [63:0]  r;
        logic [63:0]  c;
        logic [127:0] cc;
        r = '0;
        for (int b = 34; b >= 0; b--) begin
            c = r | (64'd1 << b);
            cc = {64'd0, c} * {64'd0, c};
            if (cc <= v) r = c;
        end
        return r;
    endfunction

    function automatic logic [63:0] sat31(logic [63:0] m);
        return (m > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : m;
    endfunction

    // distance from the origin to (x, y), floored and saturated
    function automatic logic [63:0] vec_len(logic signed [127:0] x, logic signed [127:0] y);
        return sat31(isqrt128(x * x + y * y));
    endfunction

    function automatic dist_res_t nearest_segment_dist(logic signed [31:0] qx,
                                                       logic signed [31:0] qy);
        logic signed [127:0] ax, ay, bx, by, px, py;
        logic signed [127:0] dx, dy, cx, cy, len2, dot, cr, ac;
        logic [127:0] q;
        logic [63:0]  mag, best;
        bit   have, neg, bneg;
        int   n;
        dist_res_t r;
        have = 0;
        bneg = 0;
        best = '0;
        px = qx;
        py = qy;
        n = (seg_count > 16) ? 16 : seg_count;
        for (int i = 0; i < n; i++) begin
            ax = tab_sx[i]; ay = tab_sy[i]; bx = tab_ex[i]; by = tab_ey[i];
            dx = bx - ax; dy = by - ay;
            cx = px - ax; cy = py - ay;
            len2 = dx * dx + dy * dy;
            dot = dx * cx + dy * cy;
            cr = dx * cy - dy * cx;
            // left normal away from the nearest point: cross strictly positive
            neg = (cr > 0);
            if (dot < 0 || len2 == 0)
                mag = vec_len(cx, cy);
            else if (dot > len2)
                mag = vec_len(px - bx, py - by);
            else begin
                ac = (cr < 0) ? -cr : cr;
                q = ac / {64'd0, isqrt128(len2)};
                mag = (q > 128'h7FFF_FFFF) ? 64'h7FFF_FFFF : q[63:0];
            end
            if (mag == 0) neg = 0;
            // earliest segment wins a tie
            if (!have || mag < best) begin
                have = 1;
                best = mag;
                bneg = neg;
            end
        end
        if (!have) begin
            r.sdist = DIST_MAX;
            r.id = pos_id;
            r.nos = 1'b1;
        end else begin
            r.sdist = bneg ? (32'd0 - best[31:0]) : best[31:0];
            r.id = (!bneg && best != 0) ? pos_id : neg_id;
            r.nos = 1'b0;
        end
        return r;
    endfunction

    // ---------------- sampling at the rising edge ----------------

    always @(posedge i_clk) begin : monitor
        dist_res_t want;
        if (!i_rst_n) begin
            item_fire <= 1'b0;
            cfg_fire <= 1'b0;
            seg_count = '0;
            neg_id = 8'd0;
            pos_id = 8'd1;
        end else begin
            item_fire <= item_ch.valid && item_ch.ready;
            cfg_fire <= cfg_ch.valid && cfg_ch.ready;
            // register writes only happen while idle, so blocking updates are safe
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    REG_SEGMENT_COUNT: seg_count = cfg_ch.data[4:0];
                    REG_NEG_REGION_ID: neg_id = cfg_ch.data;
                    REG_POS_REGION_ID: pos_id = cfg_ch.data;
                    default: ;
                endcase
            end
            // input transfer: predict the result now
            if (item_ch.valid && item_ch.ready) begin
                if (item_ch.action == ACT_LOAD) begin
                    tab_sx[item_ch.seg_index] = item_ch.start_x;
                    tab_sy[item_ch.seg_index] = item_ch.start_y;
                    tab_ex[item_ch.seg_index] = item_ch.end_x;
                    tab_ey[item_ch.seg_index] = item_ch.end_y;
                    want.sdist = '0;
                    want.id = '0;
                    want.nos = 1'b0;
                end else begin
                    want = nearest_segment_dist(item_ch.point_x, item_ch.point_y);
                end
                expected_dist = {expected_dist, want};
            end
            // output transfer: check against the oldest expectation
            if (res_ch.valid && res_ch.ready) begin
                if (expected_dist.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: dist %h id %0d nos %0d",
                                 res_ch.signed_distance, res_ch.region_id,
                                 res_ch.no_segments);
                end else begin
                    want = expected_dist.pop_front();
                    if (res_ch.signed_distance !== want.sdist || res_ch.region_id !== want.id
                        || res_ch.no_segments !== want.nos) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: dist %h/%h id %0d/%0d nos %0d/%0d (exp/got)",
                                     want.sdist, res_ch.signed_distance, want.id,
                                     res_ch.region_id, want.nos, res_ch.no_segments);
                    end
                end
            end
        end
    end

    // ---------------- driving at the falling edge ----------------

    // item driver: holds an offered item until its transfer is seen
    always @(negedge i_clk) begin : item_driver
        seg_item_t it;
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
        end else if (!item_ch.valid || item_fire) begin
            if (pending_items.size() > 0 && (no_idle || $urandom_range(99) >= 34)) begin
                it = pending_items.pop_front();
                item_ch.valid <= 1'b1;
                item_ch.action <= it.act;
                item_ch.seg_index <= it.idx;
                item_ch.start_x <= it.sx;
                item_ch.start_y <= it.sy;
                item_ch.end_x <= it.ex;
                item_ch.end_y <= it.ey;
                item_ch.point_x <= it.px;
                item_ch.point_y <= it.py;
            end else begin
                item_ch.valid <= 1'b0;
            end
        end
    end

    // result ready: random stalls, plus one long hold-off to back the block up
    always @(negedge i_clk) begin : result_ready
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            hold_left = 0;
            hold_done = 0;
        end else if (hold_go && !hold_done) begin
            hold_done = 1;
            hold_left = HOLD_CYCLES;
            res_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= no_idle || ($urandom_range(99) >= 34);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // ---------------- stimulus ----------------

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(9))
            0: return C_MIN;
            1: return C_MAX;
            2: return '0;
            3, 4: return $urandom;
            // a few units either side of the origin
            default: return $signed($urandom_range(8 << 16)) - (4 << 16);
        endcase
    endfunction

    task automatic add_load(logic [3:0] idx, logic [31:0] sx, logic [31:0] sy,
                            logic [31:0] ex, logic [31:0] ey);
        seg_item_t it;
        it.act = ACT_LOAD;
        it.idx = idx;
        it.sx = sx; it.sy = sy; it.ex = ex; it.ey = ey;
        it.px = $urandom; it.py = $urandom;
        pending_items = {pending_items, it};
    endtask

    task automatic add_query(logic [31:0] px, logic [31:0] py);
        seg_item_t it;
        it.act = ACT_QUERY;
        it.idx = 4'($urandom);
        it.sx = $urandom; it.sy = $urandom; it.ex = $urandom; it.ey = $urandom;
        it.px = px; it.py = py;
        pending_items = {pending_items, it};
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] d);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= d;
        do @(negedge i_clk); while (!cfg_fire);
        cfg_ch.valid <= 1'b0;
    endtask

    // sender pause: everything offered has come back
    task automatic drain();
        do @(negedge i_clk);
        while (pending_items.size() > 0 || item_ch.valid || expected_dist.size() > 0);
        repeat (8) @(negedge i_clk);
    endtask

    function automatic logic [4:0] pick_count();
        if ($urandom_range(9) < 6) return 5'($urandom_range(4));
        return 5'($urandom_range(31));
    endfunction

    initial begin : stimulus
        int nq;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty table: saturated distance with the flag
        add_query('0, '0);
        // fill every entry before any can take part in a query
        add_load(4'd0, '0, '0, 32'h0004_0000, '0);            // along +x
        add_load(4'd1, '0, '0, 32'h0004_0000, '0);            // duplicate: tie
        add_load(4'd2, 32'h0001_0000, 32'h0001_0000,
                       32'h0001_0000, 32'h0001_0000);         // zero length
        add_load(4'd3, C_MIN, C_MIN, C_MAX, C_MAX);            // extreme diagonal
        add_load(4'd4, C_MAX, C_MIN, C_MIN, C_MAX);
        for (int i = 5; i < 16; i++)
            add_load(i[3:0], rand_coord(), rand_coord(), rand_coord(), rand_coord());
        drain();

        write_reg(REG_SEGMENT_COUNT, 8'd1);
        write_reg(REG_NEG_REGION_ID, 8'hFF);
        write_reg(REG_POS_REGION_ID, 8'h00);
        write_reg(REG_NONE, 8'hAA);
        add_query(32'h0002_0000, 32'h0001_0000);   // left side: negative
        add_query(32'h0002_0000, 32'hFFFF_0000);   // right side: positive
        add_query(32'hFFFF_0000, 32'h0001_0000);   // before the start
        add_query(32'h0006_0000, '0);              // past the end
        add_query(32'h0001_0000, '0);              // on the segment
        add_query(C_MAX, C_MAX);                   // saturated
        add_query(C_MIN, C_MIN);
        drain();

        write_reg(REG_SEGMENT_COUNT, 8'd16);
        write_reg(REG_NEG_REGION_ID, 8'h00);
        write_reg(REG_POS_REGION_ID, 8'hFF);
        add_query(32'h0001_0000, 32'h0001_0000);
        add_query(C_MAX, C_MIN);
        drain();

        write_reg(REG_SEGMENT_COUNT, 8'hFF);       // beyond the table: all 16
        add_query(32'h0002_0000, 32'h0003_0000);
        drain();

        // long receiver hold-off while loads keep arriving
        write_reg(REG_SEGMENT_COUNT, 8'd0);
        hold_go = 1;
        for (int i = 0; i < 30; i++)
            add_load(4'($urandom), rand_coord(), rand_coord(), rand_coord(), rand_coord());
        drain();

        // random phases, each under its own register setting
        for (int ph = 0; ph < 14; ph++) begin
            no_idle = (ph == 3);
            write_reg(REG_SEGMENT_COUNT, {3'($urandom_range(7)), pick_count()});
            write_reg(REG_NEG_REGION_ID, 8'($urandom));
            write_reg(REG_POS_REGION_ID, 8'($urandom));
            if ($urandom_range(3) == 0) write_reg(REG_NONE, 8'($urandom));
            for (int k = 0; k < 50; k++) begin
                if ($urandom_range(2) == 0)
                    add_load(4'($urandom), rand_coord(), rand_coord(), rand_coord(),
                             rand_coord());
                else
                    add_query(rand_coord(), rand_coord());
            end
            drain();
        end
        no_idle = 0;

        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule

// ===== filelist.f =====
design/sdss_pkg.sv
design/sdss_ifs.sv
design/signed_distance_to_segment_set.sv
bench/tb.sv
